// ===== rtl/scc_pkg.sv =====
package scc_pkg;

    // item actions
    localparam logic [1:0] ACT_ADD     = 2'd0;
    localparam logic [1:0] ACT_COMPUTE = 2'd1;
    localparam logic [1:0] ACT_FETCH   = 2'd2;
    localparam logic [1:0] ACT_CLEAR   = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RANGE     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_READY = 3'd3;
    localparam logic [2:0] ST_NO_MORE   = 3'd4;

    // port widths
    localparam int unsigned KEY_W    = 7;
    localparam int unsigned LCOUNT_W = 12;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_ADD_WR,
        S_SWEEP,
        S_ROOT,
        S_ROOT_CHK,
        S_ENTER,
        S_ENTER2,
        S_FRAME,
        S_EDGE,
        S_VIS,
        S_POP,
        S_CL1,
        S_CL1D,
        S_CL2,
        S_CL2D,
        S_RET,
        S_RET2,
        S_RET3,
        S_LV,
        S_LV2,
        S_LE,
        S_LE2,
        S_LE3,
        S_LE4,
        S_FRD,
        S_FCHK,
        S_RESP
    } t_state;

endpackage

// ===== rtl/scc_edge_store.sv =====
module scc_edge_store #(
    parameter int unsigned VW  = 6,
    parameter int unsigned EW  = 11,
    parameter int unsigned EAW = 10,
    parameter int unsigned NV  = 64,
    parameter int unsigned NE  = 1024
) (
    input  logic           i_clk,
    input  logic           i_edge_we,
    input  logic [EAW-1:0] i_edge_waddr,
    input  logic [VW-1:0]  i_edge_wtgt,
    input  logic [EW-1:0]  i_edge_wnext,
    input  logic           i_edge_re,
    input  logic [EAW-1:0] i_edge_raddr,
    output logic [VW-1:0]  o_edge_rtgt,
    output logic [EW-1:0]  o_edge_rnext,
    input  logic           i_head_we,
    input  logic [VW-1:0]  i_head_waddr,
    input  logic [EW-1:0]  i_head_wdata,
    input  logic           i_head_re,
    input  logic [VW-1:0]  i_head_raddr,
    output logic [EW-1:0]  o_head_rdata
);
    logic [VW+EW-1:0] r_edge_mem [NE];
    logic [EW-1:0]    r_head_mem [NV];
    logic [VW+EW-1:0] r_edge_rd;

    always_ff @(posedge i_clk) begin
        if (i_edge_we) begin
            r_edge_mem[i_edge_waddr] <= {i_edge_wtgt, i_edge_wnext};
        end
        if (i_edge_re) begin
            r_edge_rd <= r_edge_mem[i_edge_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_head_we) begin
            r_head_mem[i_head_waddr] <= i_head_wdata;
        end
        if (i_head_re) begin
            o_head_rdata <= r_head_mem[i_head_raddr];
        end
    end

    assign o_edge_rtgt  = r_edge_rd[VW+EW-1:EW];
    assign o_edge_rnext = r_edge_rd[EW-1:0];
endmodule

// ===== rtl/scc_link_matrix.sv =====
module scc_link_matrix #(
    parameter int unsigned VW = 6,
    parameter int unsigned NV = 64
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [VW-1:0] i_waddr,
    input  logic [NV-1:0] i_wdata,
    input  logic          i_re,
    input  logic [VW-1:0] i_raddr,
    output logic [NV-1:0] o_rdata
);
    logic [NV-1:0] r_mem [NV];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ===== rtl/scc_condensation_engine_unit.sv =====
// Strongly connected component engine. Edges are loaded one item at a time into
// per-vertex linked lists. A clear is a pass that empties the list heads (also
// run once after reset, when no item is taken). A compute item first sweeps
// MAX_VERTICES rows of vertex flags and the link matrix, then walks Tarjan's
// algorithm over vertex, stack and frame memories with one read and one write
// port each, entering and returning from each vertex, visiting each edge and
// labelling each component member, then walks every vertex and stored edge to
// mark component links. A fetch scans the link matrix one bit a cycle within
// each row read, from the cursor, through the found link and on to the next
// one. All memories have a registered read.
module scc_condensation_engine_unit #(
    parameter int unsigned MAX_VERTICES = 64,
    parameter int unsigned MAX_EDGES    = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [scc_pkg::KEY_W-1:0]    i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_action,
    input  logic [scc_pkg::KEY_W-1:0]    i_edge_from,
    input  logic [scc_pkg::KEY_W-1:0]    i_edge_to,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_status,
    output logic [scc_pkg::KEY_W-1:0]    o_component_count,
    output logic [scc_pkg::LCOUNT_W-1:0] o_link_count,
    output logic [scc_pkg::KEY_W-1:0]    o_link_from,
    output logic [scc_pkg::KEY_W-1:0]    o_link_to,
    output logic                         o_last_link
);
    import scc_pkg::*;

    localparam int unsigned VW  = $clog2(MAX_VERTICES);
    localparam int unsigned NW  = $clog2(MAX_VERTICES + 1);
    localparam int unsigned EW  = $clog2(MAX_EDGES + 1);
    localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int unsigned LW  = $clog2(MAX_VERTICES * MAX_VERTICES + 1);
    localparam int unsigned RW  = 2 * VW + 1;
    localparam int unsigned FW  = VW + EW;

    // control registers
    t_state         r_state, n_state;
    logic [VW-1:0]  r_sw, n_sw;
    logic           r_clr_resp, n_clr_resp;
    logic [KEY_W-1:0] r_vcount, n_vcount;
    logic [EW-1:0]  r_stored, n_stored;
    logic           r_phase, n_phase;
    logic [NW-1:0]  r_comps, n_comps;
    logic [LW-1:0]  r_links, n_links;
    logic [NW-1:0]  r_ca, n_ca;
    logic [VW-1:0]  r_cb, n_cb;
    logic [NW-1:0]  r_depth, n_depth;
    logic [NW-1:0]  r_mtop, n_mtop;
    logic [NW-1:0]  r_order, n_order;
    logic           r_ovalid, n_ovalid;

    // working registers
    logic [NW-1:0]  r_root, n_root;
    logic [VW-1:0]  r_v, n_v;
    logic [VW-1:0]  r_w, n_w;
    logic [EW-1:0]  r_link, n_link;
    logic [VW-1:0]  r_vdisc, n_vdisc;
    logic [VW-1:0]  r_vlow, n_vlow;
    logic [VW-1:0]  r_clow, n_clow;
    logic [NW-1:0]  r_k, n_k;
    logic [NW-1:0]  r_i, n_i;
    logic [VW-1:0]  r_lo, n_lo;
    logic [NW-1:0]  r_la, n_la;
    logic [NW-1:0]  r_lb, n_lb;
    logic           r_second, n_second;
    logic [NW-1:0]  r_fa, n_fa;
    logic [VW-1:0]  r_fb, n_fb;
    logic [VW-1:0]  r_afrom, n_afrom;
    logic [VW-1:0]  r_ato, n_ato;
    logic [2:0]     r_st, n_st;
    logic [KEY_W-1:0] r_lf, n_lf;
    logic [KEY_W-1:0] r_lt, n_lt;
    logic           r_last, n_last;

    // output item register
    logic [2:0]          r_o_status;
    logic [KEY_W-1:0]    r_o_comps;
    logic [LCOUNT_W-1:0] r_o_links;
    logic [KEY_W-1:0]    r_o_lf;
    logic [KEY_W-1:0]    r_o_lt;
    logic                r_o_last;
    logic                w_load;

    logic [NW-1:0] w_n;
    logic          w_accept;

    // edge store ports
    logic           edge_we, edge_re, head_we, head_re;
    logic [EAW-1:0] edge_wa, edge_ra;
    logic [VW-1:0]  edge_wtgt, edge_rtgt;
    logic [EW-1:0]  edge_wnext, edge_rnext;
    logic [VW-1:0]  head_wa, head_ra;
    logic [EW-1:0]  head_wd, head_rd;

    // link matrix ports
    logic                    mtx_we, mtx_re;
    logic [VW-1:0]           mtx_wa, mtx_ra;
    logic [MAX_VERTICES-1:0] mtx_wd, mtx_rd;

    // vertex memories: record {visited, discovery, low}, on-stack flag,
    // component label, member stack, call frames {vertex, edge link}
    logic [RW-1:0] r_rec_mem  [MAX_VERTICES];
    logic          r_onstk_mem[MAX_VERTICES];
    logic [NW-1:0] r_label_mem[MAX_VERTICES];
    logic [VW-1:0] r_mstk_mem [MAX_VERTICES];
    logic [FW-1:0] r_frame_mem[MAX_VERTICES];

    logic          rec_we, rec_re, onstk_we, onstk_re, onstk_wd, onstk_rd;
    logic [VW-1:0] rec_wa, rec_ra, onstk_wa, onstk_ra;
    logic [RW-1:0] rec_wd, rec_rd;
    logic          label_we, label_re;
    logic [VW-1:0] label_wa, label_ra;
    logic [NW-1:0] label_wd, label_rd;
    logic          mstk_we, mstk_re;
    logic [VW-1:0] mstk_wa, mstk_ra, mstk_wd, mstk_rd;
    logic          frame_we, frame_re;
    logic [VW-1:0] frame_wa, frame_ra;
    logic [FW-1:0] frame_wd, frame_rd;

    logic          rec_vis;
    logic [VW-1:0] rec_disc, rec_low;
    logic [VW-1:0] bit_idx;

    assign rec_vis  = rec_rd[RW-1];
    assign rec_disc = rec_rd[2*VW-1:VW];
    assign rec_low  = rec_rd[VW-1:0];
    assign bit_idx  = VW'(r_lb - NW'(1));

    scc_edge_store #(
        .VW(VW), .EW(EW), .EAW(EAW), .NV(MAX_VERTICES), .NE(MAX_EDGES)
    ) u_edges (
        .i_clk        (i_clk),
        .i_edge_we    (edge_we),
        .i_edge_waddr (edge_wa),
        .i_edge_wtgt  (edge_wtgt),
        .i_edge_wnext (edge_wnext),
        .i_edge_re    (edge_re),
        .i_edge_raddr (edge_ra),
        .o_edge_rtgt  (edge_rtgt),
        .o_edge_rnext (edge_rnext),
        .i_head_we    (head_we),
        .i_head_waddr (head_wa),
        .i_head_wdata (head_wd),
        .i_head_re    (head_re),
        .i_head_raddr (head_ra),
        .o_head_rdata (head_rd)
    );

    scc_link_matrix #(.VW(VW), .NV(MAX_VERTICES)) u_matrix (
        .i_clk   (i_clk),
        .i_we    (mtx_we),
        .i_waddr (mtx_wa),
        .i_wdata (mtx_wd),
        .i_re    (mtx_re),
        .i_raddr (mtx_ra),
        .o_rdata (mtx_rd)
    );

    // vertex memories, one read and one write port each
    always_ff @(posedge i_clk) begin
        if (rec_we) r_rec_mem[rec_wa] <= rec_wd;
        if (rec_re) rec_rd <= r_rec_mem[rec_ra];
        if (onstk_we) r_onstk_mem[onstk_wa] <= onstk_wd;
        if (onstk_re) onstk_rd <= r_onstk_mem[onstk_ra];
        if (label_we) r_label_mem[label_wa] <= label_wd;
        if (label_re) label_rd <= r_label_mem[label_ra];
        if (mstk_we) r_mstk_mem[mstk_wa] <= mstk_wd;
        if (mstk_re) mstk_rd <= r_mstk_mem[mstk_ra];
        if (frame_we) r_frame_mem[frame_wa] <= frame_wd;
        if (frame_re) frame_rd <= r_frame_mem[frame_ra];
    end

    // active vertex count, clamped to 1..MAX_VERTICES
    always_comb begin
        if (r_vcount == '0) begin
            w_n = NW'(1);
        end else if (32'(r_vcount) > 32'(MAX_VERTICES)) begin
            w_n = NW'(MAX_VERTICES);
        end else begin
            w_n = NW'(r_vcount);
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;    n_sw = r_sw;         n_clr_resp = r_clr_resp;
        n_vcount = r_vcount;  n_stored = r_stored; n_phase = r_phase;
        n_comps = r_comps;    n_links = r_links;   n_ca = r_ca;
        n_cb = r_cb;          n_depth = r_depth;   n_mtop = r_mtop;
        n_order = r_order;    n_root = r_root;     n_v = r_v;
        n_w = r_w;            n_link = r_link;     n_vdisc = r_vdisc;
        n_vlow = r_vlow;      n_clow = r_clow;     n_k = r_k;
        n_i = r_i;            n_lo = r_lo;         n_la = r_la;
        n_lb = r_lb;          n_second = r_second; n_fa = r_fa;
        n_fb = r_fb;          n_afrom = r_afrom;   n_ato = r_ato;
        n_st = r_st;          n_lf = r_lf;         n_lt = r_lt;
        n_last = r_last;
        w_load = 1'b0;

        edge_we = 1'b0; edge_wa = '0; edge_wtgt = '0; edge_wnext = '0;
        edge_re = 1'b0; edge_ra = EAW'(r_link - EW'(1));
        head_we = 1'b0; head_wa = '0; head_wd = '0;
        head_re = 1'b0; head_ra = '0;
        mtx_we = 1'b0; mtx_wa = '0; mtx_wd = '0;
        mtx_re = 1'b0; mtx_ra = '0;
        rec_we = 1'b0; rec_wa = '0; rec_wd = '0; rec_re = 1'b0; rec_ra = '0;
        onstk_we = 1'b0; onstk_wa = '0; onstk_wd = 1'b0;
        onstk_re = 1'b0; onstk_ra = '0;
        label_we = 1'b0; label_wa = '0; label_wd = '0;
        label_re = 1'b0; label_ra = '0;
        mstk_we = 1'b0; mstk_wa = '0; mstk_wd = '0; mstk_re = 1'b0; mstk_ra = '0;
        frame_we = 1'b0; frame_wa = '0; frame_wd = '0;
        frame_re = 1'b0; frame_ra = '0;

        unique case (r_state)
            // empty every adjacency list head
            S_CLR: begin
                head_we = 1'b1;
                head_wa = r_sw;
                n_sw = r_sw + VW'(1);
                if (r_sw == VW'(MAX_VERTICES - 1)) begin
                    n_sw = '0;
                    n_state = r_clr_resp ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_st = ST_OK;
                    n_lf = '0;
                    n_lt = '0;
                    n_last = 1'b0;
                    unique case (i_action)
                        ACT_ADD: begin
                            if (i_edge_from == '0 || 32'(i_edge_from) > 32'(w_n) ||
                                i_edge_to == '0 || 32'(i_edge_to) > 32'(w_n)) begin
                                n_st = ST_RANGE;
                                n_state = S_RESP;
                            end else if (32'(r_stored) >= 32'(MAX_EDGES)) begin
                                n_st = ST_FULL;
                                n_state = S_RESP;
                            end else begin
                                head_re = 1'b1;
                                head_ra = VW'(i_edge_from - KEY_W'(1));
                                n_afrom = VW'(i_edge_from - KEY_W'(1));
                                n_ato = VW'(i_edge_to - KEY_W'(1));
                                n_state = S_ADD_WR;
                            end
                        end
                        ACT_COMPUTE: begin
                            n_comps = '0;
                            n_links = '0;
                            n_ca = '0;
                            n_cb = '0;
                            n_depth = '0;
                            n_mtop = '0;
                            n_order = '0;
                            n_phase = 1'b0;
                            n_sw = '0;
                            n_state = S_SWEEP;
                        end
                        ACT_FETCH: begin
                            if (!r_phase) begin
                                n_st = ST_NOT_READY;
                                n_state = S_RESP;
                            end else begin
                                n_fa = r_ca;
                                n_fb = r_cb;
                                n_second = 1'b0;
                                n_state = S_FRD;
                            end
                        end
                        ACT_CLEAR: begin
                            n_stored = '0;
                            n_phase = 1'b0;
                            n_sw = '0;
                            n_clr_resp = 1'b1;
                            n_state = S_CLR;
                        end
                        default: ;
                    endcase
                end
            end
            // link the new edge in front of its source list
            S_ADD_WR: begin
                edge_we = 1'b1;
                edge_wa = EAW'(r_stored);
                edge_wtgt = r_ato;
                edge_wnext = head_rd;
                head_we = 1'b1;
                head_wa = r_afrom;
                head_wd = r_stored + EW'(1);
                n_stored = r_stored + EW'(1);
                n_phase = 1'b0;
                n_state = S_RESP;
            end
            // clear vertex flags and matrix rows
            S_SWEEP: begin
                rec_we = 1'b1;
                rec_wa = r_sw;
                onstk_we = 1'b1;
                onstk_wa = r_sw;
                mtx_we = 1'b1;
                mtx_wa = r_sw;
                n_sw = r_sw + VW'(1);
                if (r_sw == VW'(MAX_VERTICES - 1)) begin
                    n_sw = '0;
                    n_root = '0;
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (r_root >= w_n) begin
                    n_root = '0;
                    n_state = S_LV;
                end else begin
                    rec_re = 1'b1;
                    rec_ra = VW'(r_root);
                    n_state = S_ROOT_CHK;
                end
            end
            S_ROOT_CHK: begin
                if (rec_vis) begin
                    n_root = r_root + NW'(1);
                    n_state = S_ROOT;
                end else begin
                    n_w = VW'(r_root);
                    n_state = S_ENTER;
                end
            end
            // save the parent frame, fetch the child's list head
            S_ENTER: begin
                head_re = 1'b1;
                head_ra = r_w;
                if (r_depth != '0) begin
                    rec_we = 1'b1;
                    rec_wa = r_v;
                    rec_wd = {1'b1, r_vdisc, r_vlow};
                    frame_we = 1'b1;
                    frame_wa = VW'(r_depth - NW'(1));
                    frame_wd = {r_v, r_link};
                end
                n_state = S_ENTER2;
            end
            S_ENTER2: begin
                rec_we = 1'b1;
                rec_wa = r_w;
                rec_wd = {1'b1, VW'(r_order), VW'(r_order)};
                onstk_we = 1'b1;
                onstk_wa = r_w;
                onstk_wd = 1'b1;
                mstk_we = 1'b1;
                mstk_wa = VW'(r_mtop);
                mstk_wd = r_w;
                frame_we = 1'b1;
                frame_wa = VW'(r_depth);
                frame_wd = {r_w, head_rd};
                n_v = r_w;
                n_link = head_rd;
                n_vdisc = VW'(r_order);
                n_vlow = VW'(r_order);
                n_order = r_order + NW'(1);
                n_mtop = r_mtop + NW'(1);
                n_depth = r_depth + NW'(1);
                n_state = S_FRAME;
            end
            S_FRAME: begin
                if (r_link != '0) begin
                    edge_re = 1'b1;
                    n_state = S_EDGE;
                end else begin
                    n_state = S_POP;
                end
            end
            S_EDGE: begin
                n_link = edge_rnext;
                if (32'(edge_rtgt) >= 32'(w_n)) begin
                    n_state = S_FRAME;
                end else begin
                    rec_re = 1'b1;
                    rec_ra = edge_rtgt;
                    onstk_re = 1'b1;
                    onstk_ra = edge_rtgt;
                    n_w = edge_rtgt;
                    n_state = S_VIS;
                end
            end
            S_VIS: begin
                if (!rec_vis) begin
                    n_state = S_ENTER;
                end else begin
                    if (onstk_rd && rec_disc < r_vlow) begin
                        n_vlow = rec_disc;
                    end
                    n_state = S_FRAME;
                end
            end
            S_POP: begin
                if (r_vlow == r_vdisc) begin
                    n_lo = r_v;
                    n_k = r_mtop;
                    n_state = S_CL1;
                end else begin
                    n_state = S_RET;
                end
            end
            // walk down the member stack to the root, tracking the smallest key
            S_CL1: begin
                mstk_re = 1'b1;
                mstk_ra = VW'(r_k - NW'(1));
                n_state = S_CL1D;
            end
            S_CL1D: begin
                if (mstk_rd < r_lo) begin
                    n_lo = mstk_rd;
                end
                n_k = r_k - NW'(1);
                if (mstk_rd == r_v) begin
                    n_i = r_k - NW'(1);
                    n_state = S_CL2;
                end else begin
                    n_state = S_CL1;
                end
            end
            // label the popped members
            S_CL2: begin
                if (r_i == r_mtop) begin
                    n_mtop = r_k;
                    n_comps = r_comps + NW'(1);
                    n_state = S_RET;
                end else begin
                    mstk_re = 1'b1;
                    mstk_ra = VW'(r_i);
                    n_state = S_CL2D;
                end
            end
            S_CL2D: begin
                label_we = 1'b1;
                label_wa = mstk_rd;
                label_wd = NW'(r_lo) + NW'(1);
                onstk_we = 1'b1;
                onstk_wa = mstk_rd;
                onstk_wd = 1'b0;
                n_i = r_i + NW'(1);
                n_state = S_CL2;
            end
            // return to the parent frame
            S_RET: begin
                if (r_depth == NW'(1)) begin
                    n_depth = '0;
                    n_root = r_root + NW'(1);
                    n_state = S_ROOT;
                end else begin
                    frame_re = 1'b1;
                    frame_ra = VW'(r_depth - NW'(2));
                    n_clow = r_vlow;
                    n_state = S_RET2;
                end
            end
            S_RET2: begin
                n_v = frame_rd[FW-1:EW];
                n_link = frame_rd[EW-1:0];
                rec_re = 1'b1;
                rec_ra = frame_rd[FW-1:EW];
                n_depth = r_depth - NW'(1);
                n_state = S_RET3;
            end
            S_RET3: begin
                n_vdisc = rec_disc;
                n_vlow = (r_clow < rec_low) ? r_clow : rec_low;
                n_state = S_FRAME;
            end
            // mark links between components, r_root walks the sources
            S_LV: begin
                if (r_root >= w_n) begin
                    n_phase = 1'b1;
                    n_ca = '0;
                    n_cb = '0;
                    n_st = ST_OK;
                    n_state = S_RESP;
                end else begin
                    head_re = 1'b1;
                    head_ra = VW'(r_root);
                    label_re = 1'b1;
                    label_ra = VW'(r_root);
                    n_state = S_LV2;
                end
            end
            S_LV2: begin
                n_link = head_rd;
                n_la = label_rd;
                n_state = S_LE;
            end
            S_LE: begin
                if (r_link == '0) begin
                    n_root = r_root + NW'(1);
                    n_state = S_LV;
                end else begin
                    edge_re = 1'b1;
                    n_state = S_LE2;
                end
            end
            S_LE2: begin
                n_link = edge_rnext;
                if (32'(edge_rtgt) >= 32'(w_n)) begin
                    n_state = S_LE;
                end else begin
                    label_re = 1'b1;
                    label_ra = edge_rtgt;
                    n_state = S_LE3;
                end
            end
            S_LE3: begin
                if (label_rd == r_la) begin
                    n_state = S_LE;
                end else begin
                    mtx_re = 1'b1;
                    mtx_ra = VW'(r_la - NW'(1));
                    n_lb = label_rd;
                    n_state = S_LE4;
                end
            end
            S_LE4: begin
                if (!mtx_rd[bit_idx]) begin
                    mtx_we = 1'b1;
                    mtx_wa = VW'(r_la - NW'(1));
                    mtx_wd = mtx_rd | (MAX_VERTICES'(1) << bit_idx);
                    n_links = r_links + LW'(1);
                end
                n_state = S_LE;
            end
            // fetch scan, one matrix bit a cycle
            S_FRD: begin
                if (r_fa == NW'(MAX_VERTICES)) begin
                    if (!r_second) begin
                        n_st = ST_NO_MORE;
                        n_ca = NW'(MAX_VERTICES);
                        n_cb = '0;
                    end else begin
                        n_last = 1'b1;
                    end
                    n_state = S_RESP;
                end else begin
                    mtx_re = 1'b1;
                    mtx_ra = VW'(r_fa);
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                if (r_fb == VW'(MAX_VERTICES - 1)) begin
                    n_fb = '0;
                    n_fa = r_fa + NW'(1);
                end else begin
                    n_fb = r_fb + VW'(1);
                    n_fa = r_fa;
                end
                if (mtx_rd[r_fb]) begin
                    if (!r_second) begin
                        n_lf = KEY_W'(r_fa + NW'(1));
                        n_lt = KEY_W'(NW'(r_fb) + NW'(1));
                        n_ca = n_fa;
                        n_cb = n_fb;
                        n_second = 1'b1;
                        n_state = S_FRD;
                    end else begin
                        n_last = 1'b0;
                        n_state = S_RESP;
                    end
                end else if (r_fb == VW'(MAX_VERTICES - 1)) begin
                    n_state = S_FRD;
                end
            end
            // hand the result to the output register once it is free
            S_RESP: begin
                if (!r_ovalid || !i_stall) begin
                    w_load = 1'b1;
                    n_clr_resp = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // register write; the user must write only while idle, the block does not enforce it
        if (i_cfg_we) begin
            n_vcount = i_cfg_data;
            n_phase = 1'b0;
        end

        if (w_load) begin
            n_ovalid = 1'b1;
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_sw       <= '0;
            r_clr_resp <= 1'b0;
            r_vcount   <= KEY_W'(64);
            r_stored   <= '0;
            r_phase    <= 1'b0;
            r_comps    <= '0;
            r_links    <= '0;
            r_ca       <= '0;
            r_cb       <= '0;
            r_depth    <= '0;
            r_mtop     <= '0;
            r_order    <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sw       <= n_sw;
            r_clr_resp <= n_clr_resp;
            r_vcount   <= n_vcount;
            r_stored   <= n_stored;
            r_phase    <= n_phase;
            r_comps    <= n_comps;
            r_links    <= n_links;
            r_ca       <= n_ca;
            r_cb       <= n_cb;
            r_depth    <= n_depth;
            r_mtop     <= n_mtop;
            r_order    <= n_order;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root   <= n_root;   r_v     <= n_v;     r_w     <= n_w;
        r_link   <= n_link;   r_vdisc <= n_vdisc; r_vlow  <= n_vlow;
        r_clow   <= n_clow;   r_k     <= n_k;     r_i     <= n_i;
        r_lo     <= n_lo;     r_la    <= n_la;    r_lb    <= n_lb;
        r_second <= n_second; r_fa    <= n_fa;    r_fb    <= n_fb;
        r_afrom  <= n_afrom;  r_ato   <= n_ato;   r_st    <= n_st;
        r_lf     <= n_lf;     r_lt    <= n_lt;    r_last  <= n_last;
        if (w_load) begin
            r_o_status <= r_st;
            r_o_comps  <= r_phase ? KEY_W'(r_comps) : '0;
            r_o_links  <= r_phase ? LCOUNT_W'(r_links) : '0;
            r_o_lf     <= r_lf;
            r_o_lt     <= r_lt;
            r_o_last   <= r_last;
        end
    end

    assign o_valid           = r_ovalid;
    assign o_status          = r_o_status;
    assign o_component_count = r_o_comps;
    assign o_link_count      = r_o_links;
    assign o_link_from       = r_o_lf;
    assign o_link_to         = r_o_lt;
    assign o_last_link       = r_o_last;

    // call depth bounded by the frame memory
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= NW'(MAX_VERTICES))
        else $error("call depth beyond frame store");

    // each component closes on a vertex already entered
    a_comps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_comps <= r_order)
        else $error("more components than entered vertices");

    // a finished compute has at least one component
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> r_comps != '0)
        else $error("computed with no components");

    // edge count never exceeds the store
    a_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored <= EW'(MAX_EDGES))
        else $error("edge store overrun");
endmodule

// ===== tb/scc_checker.sv =====
module scc_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [scc_pkg::KEY_W-1:0]    i_cfg_data,
    input  logic                         i_valid,
    input  logic                         i_in_stall,
    input  logic [1:0]                   i_action,
    input  logic [scc_pkg::KEY_W-1:0]    i_edge_from,
    input  logic [scc_pkg::KEY_W-1:0]    i_edge_to,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [2:0]                   i_status,
    input  logic [scc_pkg::KEY_W-1:0]    i_component_count,
    input  logic [scc_pkg::LCOUNT_W-1:0] i_link_count,
    input  logic [scc_pkg::KEY_W-1:0]    i_link_from,
    input  logic [scc_pkg::KEY_W-1:0]    i_link_to,
    input  logic                         i_last_link,
    output int                           o_pending,
    output int                           o_fail_count
);
    import scc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV = 64;
    localparam int NE = 1024;
    localparam int CELLS = NV * NV;

    typedef struct packed {
        logic [2:0]          status;
        logic [KEY_W-1:0]    comps;
        logic [LCOUNT_W-1:0] links;
        logic [KEY_W-1:0]    from;
        logic [KEY_W-1:0]    to;
        logic                last;
    } t_scc_result;

    t_scc_result expected_q[$];

    // graph store
    logic [5:0]  edge_dst[NE];
    logic [10:0] edge_link[NE];
    logic [10:0] list_head[NV];
    int          edge_total;
    int          vertex_reg;

    // tarjan working state
    bit          seen[NV];
    bit          stacked[NV];
    int          disc[NV];
    int          lowest[NV];
    int          members[NV];
    int          member_top;
    int          frame_vtx[NV];
    int          frame_edge[NV];
    int          frame_top;
    int          order_ctr;
    int          label[NV];
    bit          link_bit[NV][NV];
    int          comp_total;
    int          link_total;
    int          cursor;
    bit          computed;

    task automatic wipe_results();
        for (int i = 0; i < NV; i++) begin
            seen[i] = 0;
            stacked[i] = 0;
            label[i] = 0;
            for (int j = 0; j < NV; j++) link_bit[i][j] = 0;
        end
        member_top = 0;
        frame_top = 0;
        order_ctr = 0;
        comp_total = 0;
        link_total = 0;
        cursor = 0;
        computed = 0;
    endtask

    task automatic wipe_graph();
        for (int i = 0; i < NV; i++) list_head[i] = '0;
        edge_total = 0;
        wipe_results();
    endtask

    task automatic visit(input int v);
        disc[v] = order_ctr;
        lowest[v] = order_ctr;
        order_ctr++;
        seen[v] = 1;
        members[member_top++] = v;
        stacked[v] = 1;
        frame_vtx[frame_top] = v;
        frame_edge[frame_top] = list_head[v];
        frame_top++;
    endtask

    // pop members down to v, label by smallest key
    task automatic close_scc(input int v);
        int k;
        int lo;
        k = member_top;
        lo = v;
        while (k > 0) begin
            k--;
            if (members[k] < lo) lo = members[k];
            if (members[k] == v) break;
        end
        for (int i = k; i < member_top; i++) begin
            label[members[i]] = lo + 1;
            stacked[members[i]] = 0;
        end
        member_top = k;
        comp_total++;
    endtask

    task automatic find_sccs(input int n);
        int v;
        int e;
        int w;
        int p;
        for (int root = 0; root < n; root++) begin
            if (!seen[root]) begin
                visit(root);
                while (frame_top > 0) begin
                    v = frame_vtx[frame_top-1];
                    if (frame_edge[frame_top-1] != 0) begin
                        e = (frame_edge[frame_top-1] - 1) % NE;
                        w = edge_dst[e];
                        frame_edge[frame_top-1] = edge_link[e];
                        if (w < n) begin
                            if (!seen[w]) visit(w);
                            else if (stacked[w] && disc[w] < lowest[v]) lowest[v] = disc[w];
                        end
                    end else begin
                        if (lowest[v] == disc[v]) close_scc(v);
                        frame_top--;
                        if (frame_top > 0) begin
                            p = frame_vtx[frame_top-1];
                            if (lowest[v] < lowest[p]) lowest[p] = lowest[v];
                        end
                    end
                end
            end
        end
    endtask

    task automatic mark_links(input int n);
        int lnk;
        int e;
        int w;
        int a;
        int b;
        for (int v = 0; v < n; v++) begin
            lnk = list_head[v];
            while (lnk != 0) begin
                e = (lnk - 1) % NE;
                w = edge_dst[e];
                lnk = edge_link[e];
                if (w < n && label[v] != label[w]) begin
                    a = label[v] - 1;
                    b = label[w] - 1;
                    if (!link_bit[a][b]) begin
                        link_bit[a][b] = 1;
                        link_total++;
                    end
                end
            end
        end
    endtask

    function automatic int next_link(input int pos);
        for (int p = pos; p < CELLS; p++) if (link_bit[p/NV][p%NV]) return p;
        return CELLS;
    endfunction

    task automatic predict(input logic [1:0] act, input int f, input int t,
                           output t_scc_result r);
        int n;
        int pos;
        n = (vertex_reg < 1) ? 1 : ((vertex_reg > NV) ? NV : vertex_reg);
        r = '0;
        case (act)
            ACT_ADD: begin
                if (f < 1 || f > n || t < 1 || t > n) begin
                    r.status = ST_RANGE;
                end else if (edge_total >= NE) begin
                    r.status = ST_FULL;
                end else begin
                    edge_dst[edge_total] = 6'(t - 1);
                    edge_link[edge_total] = list_head[f-1];
                    list_head[f-1] = 11'(edge_total + 1);
                    edge_total++;
                    computed = 0;
                end
            end
            ACT_COMPUTE: begin
                wipe_results();
                find_sccs(n);
                mark_links(n);
                computed = 1;
            end
            ACT_FETCH: begin
                if (!computed) begin
                    r.status = ST_NOT_READY;
                end else begin
                    pos = next_link(cursor);
                    if (pos >= CELLS) begin
                        r.status = ST_NO_MORE;
                        cursor = CELLS;
                    end else begin
                        r.from = KEY_W'(pos / NV + 1);
                        r.to = KEY_W'(pos % NV + 1);
                        cursor = pos + 1;
                        r.last = next_link(cursor) >= CELLS;
                    end
                end
            end
            default: wipe_graph();
        endcase
        if (computed) begin
            r.comps = KEY_W'(comp_total);
            r.links = LCOUNT_W'(link_total);
        end
    endtask

    task automatic report(input t_scc_result want, input t_scc_result got);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t mismatch: expected st=%0d cc=%0d lc=%0d lf=%0d lt=%0d last=%0d, got st=%0d cc=%0d lc=%0d lf=%0d lt=%0d last=%0d",
                     $time, want.status, want.comps, want.links, want.from, want.to,
                     want.last, got.status, got.comps, got.links, got.from, got.to, got.last);
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        vertex_reg = NV;
        wipe_graph();
    end

    always @(posedge i_clk) begin
        t_scc_result got;
        t_scc_result want;
        if (!i_rst_n) begin
            vertex_reg = NV;
            wipe_graph();
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                vertex_reg = i_cfg_data;
                computed = 0;
            end
            // compare before predicting so a same-cycle item never matches itself
            if (i_out_valid && !i_out_stall) begin
                got = '{i_status, i_component_count, i_link_count, i_link_from,
                        i_link_to, i_last_link};
                if (expected_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) $display("%0t unexpected result", $time);
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status || got.comps !== want.comps ||
                        got.links !== want.links || got.from !== want.from ||
                        got.to !== want.to || got.last !== want.last)
                        report(want, got);
                end
            end
            if (i_valid && !i_in_stall) begin
                predict(i_action, i_edge_from, i_edge_to, want);
                expected_q.push_back(want);
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== tb/tb_scc_condensation_engine_unit.sv =====
module tb_scc_condensation_engine_unit;
    import scc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 60000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [KEY_W-1:0]    i_cfg_data;
    logic                i_valid;
    logic                o_stall;
    logic [1:0]          i_action;
    logic [KEY_W-1:0]    i_edge_from;
    logic [KEY_W-1:0]    i_edge_to;
    logic                o_valid;
    logic                i_stall;
    logic [2:0]          o_status;
    logic [KEY_W-1:0]    o_component_count;
    logic [LCOUNT_W-1:0] o_link_count;
    logic [KEY_W-1:0]    o_link_from;
    logic [KEY_W-1:0]    o_link_to;
    logic                o_last_link;

    int pending;
    int fail_count;
    int idle_pct;
    int stall_pct;
    int items_sent;
    int quiet_cycles;

    scc_condensation_engine_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_action          (i_action),
        .i_edge_from       (i_edge_from),
        .i_edge_to         (i_edge_to),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_component_count (o_component_count),
        .o_link_count      (o_link_count),
        .o_link_from       (o_link_from),
        .o_link_to         (o_link_to),
        .o_last_link       (o_last_link)
    );

    // prediction and comparison live in the checker
    scc_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .i_in_stall        (o_stall),
        .i_action          (i_action),
        .i_edge_from       (i_edge_from),
        .i_edge_to         (i_edge_to),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_status          (o_status),
        .i_component_count (o_component_count),
        .i_link_count      (o_link_count),
        .i_link_from       (o_link_from),
        .i_link_to         (o_link_to),
        .i_last_link       (o_last_link),
        .o_pending         (pending),
        .o_fail_count      (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver stalls at random, rate set per phase
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog: cycles in which neither channel moves an item
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** scc_condensation_engine_unit: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // present one item and hold it until the block takes it
    task automatic send_item(input logic [1:0] act, input int f, input int t);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_action = act;
        i_edge_from = KEY_W'(f);
        i_edge_to = KEY_W'(t);
        do begin
            #1;
            taken = !o_stall;
            @(negedge i_clk);
        end while (!taken);
        items_sent++;
    endtask

    // wait for every expected result, then let the block settle
    task automatic drain();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_count(input int value);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_data = KEY_W'(value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic pick_phase(input int k);
        case (k % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 59; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 59; end
            default: begin idle_pct = 7; stall_pct = 7; end
        endcase
    endtask

    // random edge: mostly legal keys, some noise across the full 7 bits
    task automatic random_edge(input int n);
        if ($urandom_range(9) == 0)
            send_item(ACT_ADD, $urandom_range(127), $urandom_range(127));
        else
            send_item(ACT_ADD, $urandom_range(n, 1), $urandom_range(n, 1));
    endtask

    initial begin
        int n;
        int seq;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_action = ACT_ADD;
        i_edge_from = '0;
        i_edge_to = '0;
        i_stall = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        quiet_cycles = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        // let the post-reset list clear finish
        repeat (200) @(negedge i_clk);

        // directed: fetch before compute, bad keys, cycle, self edge
        send_item(ACT_FETCH, 0, 0);
        send_item(ACT_ADD, 0, 1);
        send_item(ACT_ADD, 1, 0);
        send_item(ACT_ADD, 65, 1);
        send_item(ACT_ADD, 127, 127);
        send_item(ACT_ADD, 1, 64);
        send_item(ACT_ADD, 64, 1);
        send_item(ACT_ADD, 5, 5);
        send_item(ACT_ADD, 64, 5);
        send_item(ACT_ADD, 2, 3);
        send_item(ACT_COMPUTE, 0, 0);
        send_item(ACT_FETCH, 0, 0);
        send_item(ACT_FETCH, 0, 0);
        send_item(ACT_FETCH, 0, 0);
        // recompute restarts the fetch order
        send_item(ACT_COMPUTE, 0, 0);
        send_item(ACT_FETCH, 0, 0);
        // graph change drops the results
        send_item(ACT_ADD, 3, 2);
        send_item(ACT_FETCH, 0, 0);
        send_item(ACT_COMPUTE, 0, 0);
        send_item(ACT_FETCH, 0, 0);
        send_item(ACT_CLEAR, 0, 0);
        send_item(ACT_COMPUTE, 0, 0);
        send_item(ACT_FETCH, 0, 0);

        // shrunk vertex count hides edges to high keys
        send_item(ACT_ADD, 1, 2);
        send_item(ACT_ADD, 2, 60);
        write_count(10);
        send_item(ACT_COMPUTE, 0, 0);
        send_item(ACT_FETCH, 0, 0);
        // zero acts as one, values above the maximum act as the maximum
        write_count(0);
        send_item(ACT_ADD, 1, 1);
        send_item(ACT_ADD, 1, 2);
        send_item(ACT_COMPUTE, 0, 0);
        write_count(127);
        send_item(ACT_COMPUTE, 0, 0);
        send_item(ACT_FETCH, 0, 0);
        write_count(65);
        send_item(ACT_COMPUTE, 0, 0);

        // fill the edge store past its capacity
        write_count(64);
        send_item(ACT_CLEAR, 0, 0);
        for (int i = 0; i < 1030; i++) begin
            pick_phase(i / 260);
            send_item(ACT_ADD, $urandom_range(64, 1), $urandom_range(64, 1));
        end
        idle_pct = 0;
        stall_pct = 0;
        send_item(ACT_COMPUTE, 0, 0);
        repeat (4) send_item(ACT_FETCH, 0, 0);
        send_item(ACT_CLEAR, 0, 0);

        // random graphs: load, compute, fetch, with noise in between
        seq = 0;
        while (items_sent < 1150) begin
            pick_phase(seq);
            case ($urandom_range(7))
                0: n = 64;
                1: n = 1;
                2: n = $urandom_range(64, 17);
                default: n = $urandom_range(16, 2);
            endcase
            if (seq % 5 == 4) write_count(($urandom_range(1)) ? 0 : 127);
            else write_count(n);
            if (seq % 5 == 4) n = 1;
            if ($urandom_range(3) != 0) send_item(ACT_CLEAR, 0, 0);
            repeat ($urandom_range(30)) random_edge(n);
            send_item(ACT_COMPUTE, 0, 0);
            repeat ($urandom_range(14)) begin
                case ($urandom_range(19))
                    0: random_edge(n);
                    1: send_item(ACT_COMPUTE, 0, 0);
                    default: send_item(ACT_FETCH, $urandom_range(127), $urandom_range(127));
                endcase
            end
            // sender holds off until everything is back
            if (seq % 6 == 0) begin
                i_valid = 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            seq++;
        end

        drain();
        if (fail_count == 0) begin
            $display("** scc_condensation_engine_unit: PASSED **");
        end else begin
            $display("** scc_condensation_engine_unit: FAILED **");
        end
        $finish;
    end

endmodule
